/* sv/gamepad_report_change_events_macros.svh */
// Assertion macros shared by the gamepad report change event block.
`ifndef GAMEPAD_REPORT_CHANGE_EVENTS_MACROS_SVH
`define GAMEPAD_REPORT_CHANGE_EVENTS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GRE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gamepad report change events: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GRE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gamepad report change events: next-cycle check failed");

`endif

/* sv/gre_pkg.sv */
// Shared types and constants of the gamepad report change event block.
package gre_pkg;

    localparam int ALL_AXES     = 5;
    localparam int AXIS_BYTES   = 5;
    localparam int BUTTON_BITS  = 12;
    localparam int BUTTON_COUNT = 12;
    localparam int BTN_IDX_W    = $clog2(BUTTON_BITS);
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic [7:0] AXIS_RESET = 8'h0D;
    localparam logic [7:0] HAT_RESET  = 8'hDE;
    localparam logic [3:0] HAT_MASK   = 4'hF;
    localparam logic [BUTTON_BITS-1:0] BUTTON_EMIT_MASK =
        BUTTON_BITS'((64'd1 << BUTTON_COUNT) - 64'd1);

    typedef logic [ALL_AXES-1:0][7:0] axis_vec_t;

    typedef enum logic [1:0] {
        EV_AXES = 2'd0,
        EV_HAT  = 2'd1,
        EV_DOWN = 2'd2,
        EV_UP   = 2'd3
    } event_kind_t;

    // One classified report waiting to be turned into events.
    typedef struct packed {
        axis_vec_t              axes;
        logic                   axes_chg;
        logic [3:0]             hat;
        logic                   hat_chg;
        logic [BUTTON_BITS-1:0] buttons;
        logic [BUTTON_BITS-1:0] btn_chg;
    } job_t;

    typedef struct packed {
        logic full;
        logic valid;
    } fifo_stat_t;

endpackage

/* sv/gamepad_report_change_events.sv */
// Top level of the gamepad report change event block.
//
// Each input beat is one gamepad report (five axis bytes, hat plus buttons 1-4,
// buttons 5-12). The block compares it with the last report and sends out a run
// of events: an axes event carrying all five axes if any axis changed, a hat
// event if the hat changed, then one down or up event per changed button in
// ascending button number; m_last_event marks the final beat of a run, and an
// unchanged report yields no beat. After reset the first report always gives a
// hat event. Rate: the front end takes one report per clock as long as the
// four-entry queue has room; the back end sends one event per clock while
// m_ready is high, a report causes 1 to 14 events, and consecutive runs
// follow each other with no gap. An accepted report passes through the
// queue and the back end's job register before its first event beat is
// registered into the output. The output is registered, so a stalled
// result never blocks the input side until the queue fills.
`include "gamepad_report_change_events_macros.svh"

module gamepad_report_change_events
    import gre_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_axis_x,
    input  logic [7:0] s_axis_y,
    input  logic [7:0] s_axis_z1,
    input  logic [7:0] s_axis_z2,
    input  logic [7:0] s_axis_rz,
    input  logic [7:0] s_hat_and_low_buttons,
    input  logic [7:0] s_high_buttons,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_event_kind,
    output logic [7:0] m_out_x,
    output logic [7:0] m_out_y,
    output logic [7:0] m_out_z1,
    output logic [7:0] m_out_z2,
    output logic [7:0] m_out_rz,
    output logic [3:0] m_hat_value,
    output logic [3:0] m_button_number,
    output logic       m_last_event
);

    fifo_stat_t  fifo_stat;
    logic        push;
    logic        pop;
    job_t        push_job;
    job_t        pop_job;
    event_kind_t kind;
    logic        job_has_event;
    logic        axes_zero;
    logic        button_event;
    logic        button_ok;

    // Classify each report and keep the compare state.
    gre_front u_front (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_axis_x              (s_axis_x),
        .s_axis_y              (s_axis_y),
        .s_axis_z1             (s_axis_z1),
        .s_axis_z2             (s_axis_z2),
        .s_axis_rz             (s_axis_rz),
        .s_hat_and_low_buttons (s_hat_and_low_buttons),
        .s_high_buttons        (s_high_buttons),
        .fifo_stat             (fifo_stat),
        .push                  (push),
        .push_job              (push_job)
    );

    // Decouple classification from event output.
    gre_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (fifo_stat)
    );

    // Serialize each queued report into event beats.
    gre_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fifo_stat       (fifo_stat),
        .pop_job         (pop_job),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (kind),
        .m_out_x         (m_out_x),
        .m_out_y         (m_out_y),
        .m_out_z1        (m_out_z1),
        .m_out_z2        (m_out_z2),
        .m_out_rz        (m_out_rz),
        .m_hat_value     (m_hat_value),
        .m_button_number (m_button_number),
        .m_last_event    (m_last_event)
    );

    assign m_event_kind = kind;

    assign job_has_event = pop_job.axes_chg || pop_job.hat_chg || (pop_job.btn_chg != '0);
    assign axes_zero     = (m_out_x == 8'd0) && (m_out_y == 8'd0) && (m_out_z1 == 8'd0) &&
                           (m_out_z2 == 8'd0) && (m_out_rz == 8'd0);
    assign button_event  = (kind == EV_DOWN) || (kind == EV_UP);
    assign button_ok     = button_event ? ((m_button_number != 4'd0) &&
                                           (m_button_number <= 4'(BUTTON_COUNT)))
                                        : (m_button_number == 4'd0);

    // A queued report always carries at least one event.
    `GRE_ASSERT_NOW(a_job_not_empty, aclk, aresetn, fifo_stat.valid, job_has_event)
    // Never write into a full queue.
    `GRE_ASSERT_NOW(a_no_overflow, aclk, aresetn, push, !fifo_stat.full)
    // Fields that do not apply to an event are zero.
    `GRE_ASSERT_NOW(a_unused_zero, aclk, aresetn, m_valid && (kind != EV_AXES), axes_zero)
    // Button events carry a button number in range, others carry none.
    `GRE_ASSERT_NOW(a_button_range, aclk, aresetn, m_valid, button_ok)
    // An accepted report that causes events reaches the queue the next cycle.
    `GRE_ASSERT_NEXT(a_push_lands, aclk, aresetn, push, fifo_stat.valid)

endmodule

/* sv/gre_front.sv */
// Front end: accept a report, compare it with the stored state, queue the changes.
module gre_front
    import gre_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_axis_x,
    input  logic [7:0] s_axis_y,
    input  logic [7:0] s_axis_z1,
    input  logic [7:0] s_axis_z2,
    input  logic [7:0] s_axis_rz,
    input  logic [7:0] s_hat_and_low_buttons,
    input  logic [7:0] s_high_buttons,
    input  fifo_stat_t fifo_stat,
    output logic       push,
    output job_t       push_job
);

    logic [AXIS_BYTES-1:0][7:0] prev_axes_reg;
    logic [7:0]                 prev_hat_reg;
    logic [BUTTON_BITS-1:0]     prev_buttons_reg;

    axis_vec_t              axes;
    logic [3:0]             hat;
    logic [BUTTON_BITS-1:0] buttons;
    logic                   axes_diff;
    logic                   accept;

    assign axes    = {s_axis_rz, s_axis_z2, s_axis_z1, s_axis_y, s_axis_x};
    assign hat     = s_hat_and_low_buttons[3:0] & HAT_MASK;
    assign buttons = BUTTON_BITS'({s_high_buttons, s_hat_and_low_buttons[7:4]});

    assign s_ready = !fifo_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        axes_diff = 1'b0;
        for (int i = 0; i < AXIS_BYTES; i++) begin
            if (axes[i] != prev_axes_reg[i]) begin
                axes_diff = 1'b1;
            end
        end
    end

    always_comb begin
        push_job.axes     = axes;
        push_job.axes_chg = axes_diff;
        push_job.hat      = hat;
        push_job.hat_chg  = ({4'h0, hat} != prev_hat_reg);
        push_job.buttons  = buttons;
        push_job.btn_chg  = (buttons ^ prev_buttons_reg) & BUTTON_EMIT_MASK;
    end

    // Drop reports that change nothing.
    assign push = accept && (push_job.axes_chg || push_job.hat_chg ||
                             (push_job.btn_chg != '0));

    // Storing the report unconditionally matches storing only on change.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXIS_BYTES; i++) begin
                prev_axes_reg[i] <= AXIS_RESET;
            end
            prev_hat_reg     <= HAT_RESET;
            prev_buttons_reg <= '0;
        end else if (accept) begin
            for (int i = 0; i < AXIS_BYTES; i++) begin
                prev_axes_reg[i] <= axes[i];
            end
            prev_hat_reg     <= {4'h0, hat};
            prev_buttons_reg <= buttons;
        end
    end

endmodule

/* sv/gre_fifo.sv */
// Short queue of classified reports between the front and back ends.
module gre_fifo
    import gre_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  job_t       push_job,
    input  logic       pop,
    output job_t       pop_job,
    output fifo_stat_t stat
);

    job_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;

    assign stat.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign stat.valid = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* sv/gre_back.sv */
// Back end: turn a queued report into events, one beat per cycle unless stalled.
module gre_back
    import gre_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  fifo_stat_t  fifo_stat,
    input  job_t        pop_job,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output event_kind_t m_event_kind,
    output logic [7:0]  m_out_x,
    output logic [7:0]  m_out_y,
    output logic [7:0]  m_out_z1,
    output logic [7:0]  m_out_z2,
    output logic [7:0]  m_out_rz,
    output logic [3:0]  m_hat_value,
    output logic [3:0]  m_button_number,
    output logic        m_last_event
);

    function automatic logic [BTN_IDX_W-1:0] lowest_set(input logic [BUTTON_BITS-1:0] m);
        logic [BTN_IDX_W-1:0] idx;
        idx = '0;
        for (int i = BUTTON_BITS - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = BTN_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    job_t                 job_reg, job_next;
    logic                 job_valid_reg, job_valid_next;
    job_t                 job_after;
    logic                 load_out;
    logic                 last;
    logic [BTN_IDX_W-1:0] btn_idx;

    logic        m_valid_reg;
    event_kind_t kind_reg, kind_next;
    axis_vec_t   axes_reg, axes_next;
    logic [3:0]  hat_reg, hat_next;
    logic [3:0]  button_reg, button_next;
    logic        last_reg;

    assign load_out = job_valid_reg && (!m_valid_reg || m_ready);
    assign btn_idx  = lowest_set(job_reg.btn_chg);

    // Pick the next event: axes first, then hat, then the lowest changed button.
    always_comb begin
        job_after   = job_reg;
        kind_next   = EV_AXES;
        axes_next   = '0;
        hat_next    = '0;
        button_next = '0;
        if (job_reg.axes_chg) begin
            kind_next          = EV_AXES;
            axes_next          = job_reg.axes;
            job_after.axes_chg = 1'b0;
        end else if (job_reg.hat_chg) begin
            kind_next         = EV_HAT;
            hat_next          = job_reg.hat;
            job_after.hat_chg = 1'b0;
        end else begin
            kind_next         = job_reg.buttons[btn_idx] ? EV_DOWN : EV_UP;
            button_next       = 4'(btn_idx) + 4'd1;
            job_after.btn_chg = job_reg.btn_chg & (job_reg.btn_chg - BUTTON_BITS'(1));
        end
        last = !(job_after.axes_chg || job_after.hat_chg || (job_after.btn_chg != '0));
    end

    // Refill the job register as its final event leaves, so runs stay gapless.
    always_comb begin
        pop            = fifo_stat.valid && (!job_valid_reg || (load_out && last));
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        if (pop) begin
            job_next       = pop_job;
            job_valid_next = 1'b1;
        end else if (load_out) begin
            job_next       = job_after;
            job_valid_next = !last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        if (load_out) begin
            kind_reg   <= kind_next;
            axes_reg   <= axes_next;
            hat_reg    <= hat_next;
            button_reg <= button_next;
            last_reg   <= last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_event_kind    = kind_reg;
    assign m_out_x         = axes_reg[0];
    assign m_out_y         = axes_reg[1];
    assign m_out_z1        = axes_reg[2];
    assign m_out_z2        = axes_reg[3];
    assign m_out_rz        = axes_reg[4];
    assign m_hat_value     = hat_reg;
    assign m_button_number = button_reg;
    assign m_last_event    = last_reg;

endmodule

/* tb/gamepad_report_change_events_tb.sv */
// Self-checking testbench for the gamepad report change event block.
module gamepad_report_change_events_tb
    import gre_pkg::*;
();

    // One gamepad report as it enters the block; axes[0] is X, axes[4] is Rz.
    typedef struct {
        axis_vec_t  axes;
        logic [7:0] hat_btn;
        logic [7:0] hi_btn;
    } report_t;

    // One event beat as the block should send it.
    typedef struct {
        event_kind_t kind;
        axis_vec_t   axes;
        logic [3:0]  hat;
        logic [3:0]  button;
        logic        is_last;
    } change_event_t;

    typedef enum {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_axis_x = '0;
    logic [7:0] s_axis_y = '0;
    logic [7:0] s_axis_z1 = '0;
    logic [7:0] s_axis_z2 = '0;
    logic [7:0] s_axis_rz = '0;
    logic [7:0] s_hat_and_low_buttons = '0;
    logic [7:0] s_high_buttons = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_event_kind;
    logic [7:0] m_out_x;
    logic [7:0] m_out_y;
    logic [7:0] m_out_z1;
    logic [7:0] m_out_z2;
    logic [7:0] m_out_rz;
    logic [3:0] m_hat_value;
    logic [3:0] m_button_number;
    logic       m_last_event;

    // Mirror of the block's memory of the previous report.
    axis_vec_t               held_axes;
    logic [7:0]              held_hat;
    logic [BUTTON_BITS-1:0]  held_buttons;

    // Events the block still owes, oldest first.
    change_event_t due_events[$];

    report_t    last_sent;
    idle_mode_t send_idle = IDLE_SOME;
    idle_mode_t recv_idle = IDLE_SOME;
    int         stall_left = 0;
    int         reports_sent = 0;
    int         quiet_reports = 0;
    int         events_seen = 0;
    int         errors = 0;

    gamepad_report_change_events u_top (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_axis_x              (s_axis_x),
        .s_axis_y              (s_axis_y),
        .s_axis_z1             (s_axis_z1),
        .s_axis_z2             (s_axis_z2),
        .s_axis_rz             (s_axis_rz),
        .s_hat_and_low_buttons (s_hat_and_low_buttons),
        .s_high_buttons        (s_high_buttons),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_event_kind          (m_event_kind),
        .m_out_x               (m_out_x),
        .m_out_y               (m_out_y),
        .m_out_z1              (m_out_z1),
        .m_out_z2              (m_out_z2),
        .m_out_rz              (m_out_rz),
        .m_hat_value           (m_hat_value),
        .m_button_number       (m_button_number),
        .m_last_event          (m_last_event)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle stretch per mode: none; mostly none or short, rarely long; mostly long.
    function automatic int pick_gap(input idle_mode_t mode);
        int roll;
        roll = $urandom_range(0, 15);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_SOME: begin
                if (roll < 9)
                    return 0;
                else if (roll < 14)
                    return $urandom_range(1, 3);
                else
                    return $urandom_range(8, 40);
            end
            default: begin
                if (roll < 4)
                    return 0;
                else
                    return $urandom_range(5, 30);
            end
        endcase
    endfunction

    // Work out the events a report causes and advance the held state.
    // Order: axes first, then hat, then buttons from 1 upward.
    function automatic void derive_events(input report_t r);
        change_event_t          ev;
        logic                   axes_moved;
        logic [BUTTON_BITS-1:0] now_buttons;
        logic [BUTTON_BITS-1:0] flipped;
        int                     first;
        first = due_events.size();
        axes_moved = 1'b0;
        for (int i = 0; i < AXIS_BYTES; i++) begin
            if (r.axes[i] != held_axes[i])
                axes_moved = 1'b1;
        end
        if (axes_moved) begin
            ev = '{kind: EV_AXES, axes: r.axes, hat: 4'h0, button: 4'h0, is_last: 1'b0};
            due_events.push_back(ev);
            for (int i = 0; i < AXIS_BYTES; i++)
                held_axes[i] = r.axes[i];
        end
        // The reset value of the held hat lies outside four bits, so the first
        // report always reports its hat.
        if ({4'h0, r.hat_btn[3:0]} != held_hat) begin
            ev = '{kind: EV_HAT, axes: '0, hat: r.hat_btn[3:0], button: 4'h0, is_last: 1'b0};
            due_events.push_back(ev);
            held_hat = {4'h0, r.hat_btn[3:0]};
        end
        now_buttons = {r.hi_btn, r.hat_btn[7:4]};
        flipped = now_buttons ^ held_buttons;
        if (flipped != '0) begin
            for (int i = 0; i < BUTTON_BITS; i++) begin
                if (i < BUTTON_COUNT && flipped[i]) begin
                    ev = '{kind: now_buttons[i] ? EV_DOWN : EV_UP, axes: '0, hat: 4'h0,
                           button: 4'(i + 1), is_last: 1'b0};
                    due_events.push_back(ev);
                end
            end
            held_buttons = now_buttons;
        end
        if (due_events.size() > first)
            due_events[due_events.size() - 1].is_last = 1'b1;
        else
            quiet_reports++;
    endfunction

    function automatic report_t compose_report(input logic [7:0] x, input logic [7:0] y,
                                               input logic [7:0] z1, input logic [7:0] z2,
                                               input logic [7:0] rz, input logic [7:0] hb,
                                               input logic [7:0] hi);
        report_t r;
        r.axes[0] = x;
        r.axes[1] = y;
        r.axes[2] = z1;
        r.axes[3] = z2;
        r.axes[4] = rz;
        r.hat_btn = hb;
        r.hi_btn = hi;
        return r;
    endfunction

    // Drive one report, hold it until the block takes the beat, then maybe idle.
    task automatic send_report(input report_t r);
        int gap;
        @(negedge aclk);
        s_valid = 1'b1;
        s_axis_x = r.axes[0];
        s_axis_y = r.axes[1];
        s_axis_z1 = r.axes[2];
        s_axis_z2 = r.axes[3];
        s_axis_rz = r.axes[4];
        s_hat_and_low_buttons = r.hat_btn;
        s_high_buttons = r.hi_btn;
        do
            @(posedge aclk);
        while (!s_ready);
        derive_events(r);
        last_sent = r;
        reports_sent++;
        gap = pick_gap(send_idle);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Mostly a plausible next report from the previous one: a few axes drift,
    // the hat moves, some buttons toggle. Mix in exact repeats and full noise.
    function automatic report_t next_report(input report_t prev);
        report_t                r;
        logic [BUTTON_BITS-1:0] toggles;
        int                     pick;
        r = prev;
        pick = $urandom_range(0, 19);
        if (pick >= 3 && pick < 6) begin
            for (int i = 0; i < ALL_AXES; i++)
                r.axes[i] = 8'($urandom);
            r.hat_btn = 8'($urandom);
            r.hi_btn = 8'($urandom);
        end else if (pick >= 6) begin
            for (int i = 0; i < ALL_AXES; i++) begin
                if ($urandom_range(0, 3) == 0)
                    r.axes[i] = r.axes[i] + 8'($urandom_range(1, 255));
            end
            if ($urandom_range(0, 3) == 0)
                r.hat_btn[3:0] = 4'($urandom);
            if ($urandom_range(0, 1) == 0) begin
                toggles = BUTTON_BITS'($urandom & $urandom & $urandom);
                r.hat_btn[7:4] = r.hat_btn[7:4] ^ toggles[3:0];
                r.hi_btn = r.hi_btn ^ toggles[11:4];
            end
        end
        return r;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            send_report(next_report(last_sent));
    endtask

    // First report after reset: hat always reported; a repeat is silent.
    task automatic test_first_report();
        send_report(compose_report(AXIS_RESET, AXIS_RESET, AXIS_RESET, AXIS_RESET,
                                   AXIS_RESET, 8'h00, 8'h00));
        send_report(compose_report(AXIS_RESET, AXIS_RESET, AXIS_RESET, AXIS_RESET,
                                   AXIS_RESET, 8'h00, 8'h00));
    endtask

    // Axis extremes, then one axis changing at a time.
    task automatic test_axis_extremes();
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(compose_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_report(compose_report(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_report(compose_report(8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00));
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00));
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic test_hat_moves();
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0F, 8'h00));
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00));
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // All buttons down and up, alternating patterns, first and last button alone.
    task automatic test_button_edges();
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF0, 8'hFF));
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h50, 8'hAA));
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA0, 8'h55));
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00));
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80));
    endtask

    // Axes, hat and all twelve buttons change at once: the longest run.
    task automatic test_longest_run();
        send_report(compose_report(8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'h7E, 8'hF7, 8'h7F));
        send_report(compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80));
    endtask

    task automatic test_random_with_gaps();
        send_idle = IDLE_SOME;
        recv_idle = IDLE_SOME;
        run_random(140);
    endtask

    task automatic test_back_to_back();
        send_idle = IDLE_NONE;
        recv_idle = IDLE_NONE;
        run_random(75);
    endtask

    // Stall the output hard so the internal queue fills and pushes back.
    task automatic test_output_backpressure();
        send_idle = IDLE_NONE;
        recv_idle = IDLE_HEAVY;
        run_random(75);
    endtask

    // Hold m_ready low for random stretches, changing it at the falling edge.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = 1'b1;
            stall_left = pick_gap(recv_idle);
        end
    end

    task automatic check_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: event %0d %s expected %0d actual %0d",
                     $time, events_seen, what, want_v, got_v);
            errors++;
        end
    endtask

    // Compare every event beat with the oldest outstanding prediction.
    always @(posedge aclk) begin : check_events
        change_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_events.size() == 0) begin
                $display("%0t: unexpected event beat, expected none, actual kind %0d",
                         $time, m_event_kind);
                errors++;
            end else begin
                want = due_events.pop_front();
                check_field("event_kind", want.kind, m_event_kind);
                check_field("out_x", want.axes[0], m_out_x);
                check_field("out_y", want.axes[1], m_out_y);
                check_field("out_z1", want.axes[2], m_out_z1);
                check_field("out_z2", want.axes[3], m_out_z2);
                check_field("out_rz", want.axes[4], m_out_rz);
                check_field("hat_value", want.hat, m_hat_value);
                check_field("button_number", want.button, m_button_number);
                check_field("last_event", want.is_last, m_last_event);
            end
            events_seen++;
        end
    end

    initial begin
        held_axes = {ALL_AXES{AXIS_RESET}};
        held_hat = HAT_RESET;
        held_buttons = '0;
        last_sent = compose_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_first_report();
        test_axis_extremes();
        test_hat_moves();
        test_button_edges();
        test_longest_run();
        test_random_with_gaps();
        test_back_to_back();
        test_output_backpressure();

        // Release the input, drain every owed event, then watch for strays.
        @(negedge aclk);
        s_valid = 1'b0;
        recv_idle = IDLE_SOME;
        while (due_events.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d reports sent (%0d with no change), %0d event beats checked",
                 reports_sent, quiet_reports, events_seen);
        $display("phases: directed edges, gapped random, back-to-back, heavy output stall");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Bound the run well beyond the slowest legal completion.
    initial begin
        #7_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
